[rtl/frtw_pkg.sv]
`timescale 1ns / 1ps

package frtw_pkg;

  // field and register widths
  localparam int XW = 12;
  localparam int OW = 32;
  localparam int RW = 16;

  // register indexes
  localparam logic REG_FOCAL = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam logic [RW-1:0] FOCAL_RESET = 16'd9216;
  localparam logic [RW-1:0] SCALE_RESET = 16'd4096;

  // square root: 56-bit radicand, 28 result bits, one bit per cell
  localparam int SQ_N  = 28;
  localparam int SQ_VW = 56;
  localparam int SQ_MW = 30;

  // long division chains: divisor width and quotient bits (one per cell)
  localparam int TH_DW = 16;
  localparam int TH_QW = 31;
  localparam int TA_DW = 31;
  localparam int TA_QW = 33;
  localparam int RA_DW = 31;
  localparam int RA_QW = 45;

  // CORDIC datapath width
  localparam int CDW = 34;

  localparam logic [TH_QW-1:0] THETA_LIMIT = 31'h6400_0000;

  // stage 0, sqrt, theta, tangent, ratio and four multiply/format stages
  localparam int FIXED_LAT = 1 + SQ_N + TH_QW + TA_QW + RA_QW + 4;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 nz;
  } pt_t;

  typedef struct packed {
    pt_t  pt;
    logic sat;
  } pts_t;

  typedef struct packed {
    pt_t              pt;
    logic             sat;
    logic [TH_QW-1:0] theta;
  } ptt_t;

  function automatic int frtw_latency(input int cordic_stages);
    return FIXED_LAT + cordic_stages;
  endfunction

endpackage

[rtl/frtw_sqrt_cell.sv]
`timescale 1ns / 1ps

module frtw_sqrt_cell #(
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [frtw_pkg::SQ_VW-1:0] in_sh,
  input  logic [frtw_pkg::SQ_MW-1:0] in_rem,
  input  logic [frtw_pkg::SQ_N-1:0]  in_root,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [frtw_pkg::SQ_VW-1:0] out_sh,
  output logic [frtw_pkg::SQ_MW-1:0] out_rem,
  output logic [frtw_pkg::SQ_N-1:0]  out_root,
  output logic [SW-1:0]             out_side
);
  import frtw_pkg::*;

  logic [SQ_MW+1:0] t;
  logic [SQ_MW+1:0] trial;
  logic [SQ_MW+1:0] diff;
  logic             ge;

  always_comb begin
    t     = {in_rem, in_sh[SQ_VW-1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    ge    = (t >= trial);
    diff  = t - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_sh   <= {in_sh[SQ_VW-3:0], 2'b00};
    out_rem  <= ge ? diff[SQ_MW-1:0] : t[SQ_MW-1:0];
    out_root <= {in_root[SQ_N-2:0], ge};
    out_side <= in_side;
  end

endmodule

[rtl/frtw_div_cell.sv]
`timescale 1ns / 1ps

module frtw_div_cell #(
  parameter int DW = 16,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_sh,
  input  logic [DW-1:0] in_d,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [QW-1:0] out_sh,
  output logic [DW-1:0] out_d,
  output logic [SW-1:0] out_side
);

  // sh holds the dividend bits still to come at the top and the quotient
  // bits found so far at the bottom
  logic [DW:0] t;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    t    = {in_rem, in_sh[QW-1]};
    ge   = (t >= {1'b0, in_d});
    diff = t - {1'b0, in_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= ge ? diff[DW-1:0] : t[DW-1:0];
    out_sh   <= {in_sh[QW-2:0], ge};
    out_d    <= in_d;
    out_side <= in_side;
  end

endmodule

[rtl/frtw_cordic_cell.sv]
`timescale 1ns / 1ps

module frtw_cordic_cell #(
  parameter int STAGE = 0,
  parameter int SW    = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [frtw_pkg::CDW-1:0]  in_cx,
  input  logic signed [frtw_pkg::CDW-1:0]  in_sy,
  input  logic signed [frtw_pkg::CDW-1:0]  in_z,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic signed [frtw_pkg::CDW-1:0]  out_cx,
  output logic signed [frtw_pkg::CDW-1:0]  out_sy,
  output logic signed [frtw_pkg::CDW-1:0]  out_z,
  output logic [SW-1:0]                    out_side
);
  import frtw_pkg::*;

  localparam logic signed [CDW-1:0] ANG = signed'({2'b00, ATAN_Q30[STAGE]});

  logic signed [CDW-1:0] dx;
  logic signed [CDW-1:0] dy;

  always_comb begin
    dx = in_sy >>> STAGE;
    dy = in_cx >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    if (!in_z[CDW-1]) begin
      out_cx <= in_cx - dx;
      out_sy <= in_sy + dy;
      out_z  <= in_z - ANG;
    end else begin
      out_cx <= in_cx + dx;
      out_sy <= in_sy - dy;
      out_z  <= in_z + ANG;
    end
    out_side <= in_side;
  end

endmodule

[rtl/fisheye_radial_tan_warp_unit.sv]
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------
// input    | start, busy        | point_x, point_y
// result   | done (one cycle)   | warped_x, warped_y, saturated
// config   | cfg_we             | cfg_addr, cfg_wdata
//
// One item per cycle; busy is high only during reset.
// Each item passes through stage 0 and the cell chains: 28 square
// root cells, 31 + 33 + 45 long division cells, the CORDIC cells and four
// multiply and format stages.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall; each result is shown for one cycle on done.

module fisheye_radial_tan_warp_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [frtw_pkg::XW-1:0]   point_x,
  input  logic signed [frtw_pkg::XW-1:0]   point_y,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [frtw_pkg::RW-1:0]          cfg_wdata,
  output logic                             done,
  output logic signed [frtw_pkg::OW-1:0]   warped_x,
  output logic signed [frtw_pkg::OW-1:0]   warped_y,
  output logic                             saturated
);
  import frtw_pkg::*;

  // ---------------- configuration
  logic [RW-1:0] focal_length;
  logic [RW-1:0] output_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length <= FOCAL_RESET;
      output_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FOCAL: focal_length <= cfg_wdata;
        REG_SCALE: output_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // ---------------- stage 0: radius squared
  logic signed [2*XW-1:0] xx;
  logic signed [2*XW-1:0] yy;
  logic [2*XW-1:0]        r2;

  always_comb begin
    xx = (2*XW)'(point_x) * (2*XW)'(point_x);
    yy = (2*XW)'(point_y) * (2*XW)'(point_y);
    r2 = unsigned'(xx) + unsigned'(yy);
  end

  logic             sq_v    [0:SQ_N];
  logic [SQ_VW-1:0] sq_sh   [0:SQ_N];
  logic [SQ_MW-1:0] sq_rem  [0:SQ_N];
  logic [SQ_N-1:0]  sq_root [0:SQ_N];
  pt_t              sq_pt   [0:SQ_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= start & ~busy;
    end
    sq_sh[0] <= {r2, {(SQ_VW-2*XW){1'b0}}};
    sq_pt[0] <= '{x: point_x, y: point_y, nz: (point_x != '0) || (point_y != '0)};
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    frtw_sqrt_cell #(.SW($bits(pt_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_sh    (sq_sh[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_pt[i]),
      .out_valid(sq_v[i+1]),
      .out_sh   (sq_sh[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_pt[i+1])
    );
  end

  // ---------------- theta = (rho << 18) / focal_length
  logic             th_v   [0:TH_QW];
  logic [TH_DW-1:0] th_rem [0:TH_QW];
  logic [TH_QW-1:0] th_sh  [0:TH_QW];
  logic [TH_DW-1:0] th_d   [0:TH_QW];
  pts_t             th_s   [0:TH_QW];

  logic [SQ_N-1:0] rho;

  always_comb begin
    rho       = sq_root[SQ_N];
    th_v[0]   = sq_v[SQ_N];
    th_rem[0] = {1'b0, rho[SQ_N-1:13]};
    th_sh[0]  = {rho[12:0], 18'd0};
    th_d[0]   = focal_length;
    // quotient would reach 2^31, or focal length is zero
    th_s[0]   = '{pt: sq_pt[SQ_N], sat: ({1'b0, rho[SQ_N-1:13]} >= focal_length)};
  end

  for (genvar i = 0; i < TH_QW; i++) begin : g_theta
    frtw_div_cell #(.DW(TH_DW), .QW(TH_QW), .SW($bits(pts_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (th_v[i]),
      .in_rem   (th_rem[i]),
      .in_sh    (th_sh[i]),
      .in_d     (th_d[i]),
      .in_side  (th_s[i]),
      .out_valid(th_v[i+1]),
      .out_rem  (th_rem[i+1]),
      .out_sh   (th_sh[i+1]),
      .out_d    (th_d[i+1]),
      .out_side (th_s[i+1])
    );
  end

  // ---------------- CORDIC rotation
  logic                  co_v  [0:CORDIC_STAGES];
  logic signed [CDW-1:0] co_cx [0:CORDIC_STAGES];
  logic signed [CDW-1:0] co_sy [0:CORDIC_STAGES];
  logic signed [CDW-1:0] co_z  [0:CORDIC_STAGES];
  ptt_t                  co_s  [0:CORDIC_STAGES];

  logic [TH_QW-1:0] theta;

  always_comb begin
    theta    = th_sh[TH_QW];
    co_v[0]  = th_v[TH_QW];
    co_cx[0] = CDW'(35'sh0_4000_0000);
    co_sy[0] = '0;
    co_z[0]  = signed'({3'b000, theta});
    co_s[0]  = '{pt: th_s[TH_QW].pt, sat: th_s[TH_QW].sat | (theta >= THETA_LIMIT),
                 theta: theta};
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    frtw_cordic_cell #(.STAGE(i), .SW($bits(ptt_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (co_v[i]),
      .in_cx    (co_cx[i]),
      .in_sy    (co_sy[i]),
      .in_z     (co_z[i]),
      .in_side  (co_s[i]),
      .out_valid(co_v[i+1]),
      .out_cx   (co_cx[i+1]),
      .out_sy   (co_sy[i+1]),
      .out_z    (co_z[i+1]),
      .out_side (co_s[i+1])
    );
  end

  // ---------------- tan = (max(sin,0) << 24) / cos
  logic             ta_v   [0:TA_QW];
  logic [TA_DW-1:0] ta_rem [0:TA_QW];
  logic [TA_QW-1:0] ta_sh  [0:TA_QW];
  logic [TA_DW-1:0] ta_d   [0:TA_QW];
  ptt_t             ta_s   [0:TA_QW];

  logic signed [CDW-1:0] cx_f;
  logic [TA_DW-1:0]      syc;
  logic                  cos_bad;
  logic [TA_DW-1:0]      ta_rem0;

  always_comb begin
    cx_f      = co_cx[CORDIC_STAGES];
    syc       = co_sy[CORDIC_STAGES][CDW-1] ? '0 : co_sy[CORDIC_STAGES][TA_DW-1:0];
    cos_bad   = cx_f[CDW-1] || (cx_f == '0);
    ta_rem0   = {9'd0, syc[TA_DW-1:9]};
    ta_v[0]   = co_v[CORDIC_STAGES];
    ta_rem[0] = ta_rem0;
    ta_sh[0]  = {syc[8:0], 24'd0};
    ta_d[0]   = cx_f[TA_DW-1:0];
    // quotient would reach 2^33, or cos is zero or negative
    ta_s[0]   = '{pt: co_s[CORDIC_STAGES].pt,
                  sat: co_s[CORDIC_STAGES].sat | cos_bad | (ta_rem0 >= cx_f[TA_DW-1:0]),
                  theta: co_s[CORDIC_STAGES].theta};
  end

  for (genvar i = 0; i < TA_QW; i++) begin : g_tan
    frtw_div_cell #(.DW(TA_DW), .QW(TA_QW), .SW($bits(ptt_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (ta_v[i]),
      .in_rem   (ta_rem[i]),
      .in_sh    (ta_sh[i]),
      .in_d     (ta_d[i]),
      .in_side  (ta_s[i]),
      .out_valid(ta_v[i+1]),
      .out_rem  (ta_rem[i+1]),
      .out_sh   (ta_sh[i+1]),
      .out_d    (ta_d[i+1]),
      .out_side (ta_s[i+1])
    );
  end

  // ---------------- ratio = (tan << 30) / theta
  logic             ra_v   [0:RA_QW];
  logic [RA_DW-1:0] ra_rem [0:RA_QW];
  logic [RA_QW-1:0] ra_sh  [0:RA_QW];
  logic [RA_DW-1:0] ra_d   [0:RA_QW];
  pts_t             ra_s   [0:RA_QW];

  logic [TA_QW-1:0] tan_q;

  always_comb begin
    tan_q     = ta_sh[TA_QW];
    ra_v[0]   = ta_v[TA_QW];
    ra_rem[0] = {13'd0, tan_q[TA_QW-1:15]};
    ra_sh[0]  = {tan_q[14:0], 30'd0};
    ra_d[0]   = ta_s[TA_QW].theta;
    ra_s[0]   = '{pt: ta_s[TA_QW].pt, sat: ta_s[TA_QW].sat};
  end

  for (genvar i = 0; i < RA_QW; i++) begin : g_ratio
    frtw_div_cell #(.DW(RA_DW), .QW(RA_QW), .SW($bits(pts_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (ra_v[i]),
      .in_rem   (ra_rem[i]),
      .in_sh    (ra_sh[i]),
      .in_d     (ra_d[i]),
      .in_side  (ra_s[i]),
      .out_valid(ra_v[i+1]),
      .out_rem  (ra_rem[i+1]),
      .out_sh   (ra_sh[i+1]),
      .out_d    (ra_d[i+1]),
      .out_side (ra_s[i+1])
    );
  end

  // ---------------- scale, round and clip
  function automatic logic [OW-1:0] sat_value(input logic signed [XW-1:0] c);
    logic [OW-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (c[XW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // returns {clip, value}
  function automatic logic [OW:0] finish_coord(input logic signed [XW-1:0] c,
                                               input logic [35:0] q);
    logic [OW:0] r;
    if (!c[XW-1]) begin
      if (q > 36'h0_7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, q[OW-1:0]};
      end
    end else begin
      if (q > 36'h0_8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, (~q[OW-1:0]) + 32'd1};
      end
    end
    return r;
  endfunction

  logic [RA_QW-1:0] ratio;
  logic [XW-1:0]    mag_x;
  logic [XW-1:0]    mag_y;

  always_comb begin
    ratio = ra_sh[RA_QW];
    mag_x = ra_s[RA_QW].pt.x[XW-1] ? XW'(-ra_s[RA_QW].pt.x) : ra_s[RA_QW].pt.x;
    mag_y = ra_s[RA_QW].pt.y[XW-1] ? XW'(-ra_s[RA_QW].pt.y) : ra_s[RA_QW].pt.y;
  end

  // M1: scale * |coord|
  logic             m1_v;
  pts_t             m1_s;
  logic [RA_QW-1:0] m1_ratio;
  logic [27:0]      m1_ax;
  logic [27:0]      m1_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= ra_v[RA_QW];
    end
    m1_s     <= ra_s[RA_QW];
    m1_ratio <= ratio;
    m1_ax    <= 28'(output_scale) * 28'(mag_x);
    m1_ay    <= 28'(output_scale) * 28'(mag_y);
  end

  // M2: partial products against the low 23 and high 22 ratio bits
  logic        m2_v;
  pts_t        m2_s;
  logic [50:0] m2_xlo;
  logic [49:0] m2_xhi;
  logic [50:0] m2_ylo;
  logic [49:0] m2_yhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else begin
      m2_v <= m1_v;
    end
    m2_s   <= m1_s;
    m2_xlo <= 51'(m1_ax) * 51'(m1_ratio[22:0]);
    m2_xhi <= 50'(m1_ax) * 50'(m1_ratio[RA_QW-1:23]);
    m2_ylo <= 51'(m1_ay) * 51'(m1_ratio[22:0]);
    m2_yhi <= 50'(m1_ay) * 50'(m1_ratio[RA_QW-1:23]);
  end

  // M3: product mod 2^64, round, shift down
  logic        m3_v;
  pts_t        m3_s;
  logic [35:0] m3_qx;
  logic [35:0] m3_qy;
  logic [63:0] sum_x;
  logic [63:0] sum_y;

  always_comb begin
    sum_x = 64'(m2_xlo) + {m2_xhi[40:0], 23'd0} + 64'h0000_0000_0800_0000;
    sum_y = 64'(m2_ylo) + {m2_yhi[40:0], 23'd0} + 64'h0000_0000_0800_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else begin
      m3_v <= m2_v;
    end
    m3_s  <= m2_s;
    m3_qx <= sum_x[63:28];
    m3_qy <= sum_y[63:28];
  end

  // M4: sign, clip and special cases
  logic [OW:0]   fin_x;
  logic [OW:0]   fin_y;
  logic [OW-1:0] wx_next;
  logic [OW-1:0] wy_next;
  logic          flag_next;

  always_comb begin
    fin_x = finish_coord(m3_s.pt.x, m3_qx);
    fin_y = finish_coord(m3_s.pt.y, m3_qy);
    if (!m3_s.pt.nz) begin
      wx_next   = '0;
      wy_next   = '0;
      flag_next = 1'b0;
    end else if (m3_s.sat) begin
      wx_next   = sat_value(m3_s.pt.x);
      wy_next   = sat_value(m3_s.pt.y);
      flag_next = 1'b1;
    end else begin
      wx_next   = fin_x[OW-1:0];
      wy_next   = fin_y[OW-1:0];
      flag_next = fin_x[OW] | fin_y[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m3_v;
    end
    warped_x  <= signed'(wx_next);
    warped_y  <= signed'(wy_next);
    saturated <= flag_next;
  end

endmodule

[rtl/frtw_checker.sv]
`timescale 1ns / 1ps

module frtw_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic signed [frtw_pkg::XW-1:0] point_x,
  input logic signed [frtw_pkg::XW-1:0] point_y,
  input logic                           done,
  input logic signed [frtw_pkg::OW-1:0] warped_x,
  input logic signed [frtw_pkg::OW-1:0] warped_y,
  input logic                           saturated
);
  import frtw_pkg::*;

  localparam int LAT = frtw_latency(CORDIC_STAGES);

  logic accept;
  assign accept = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("item accepted but no result after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching item");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    (accept && point_x == '0 && point_y == '0) |->
      ##LAT (done && warped_x == '0 && warped_y == '0 && !saturated))
    else $error("origin did not map to origin");

  a_sign_x: assert property (@(posedge clk) disable iff (rst)
    (accept && point_x[XW-1]) |-> ##LAT (warped_x[OW-1] || warped_x == '0))
    else $error("negative x gave positive result");

endmodule

bind fisheye_radial_tan_warp_unit frtw_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_frtw_checker (.*);
